### src/mm_pkg.sv
package mm_pkg;

    localparam int VAL_W     = 32;
    localparam int DIM_W     = 3;
    localparam int CFG_W     = 4;
    localparam int CMD_W     = 2;
    localparam int REG_IDX_W = 2;
    localparam int PROD_W    = 2 * VAL_W;
    // eight full-scale products need three guard bits
    localparam int ACC_W     = PROD_W + DIM_W;

    localparam logic [CMD_W-1:0] CMD_LOAD_A  = 2'd0;
    localparam logic [CMD_W-1:0] CMD_LOAD_B  = 2'd1;
    localparam logic [CMD_W-1:0] CMD_COMPUTE = 2'd2;

    localparam logic [REG_IDX_W-1:0] REG_ROWS_A = 2'd0;
    localparam logic [REG_IDX_W-1:0] REG_COLS_A = 2'd1;
    localparam logic [REG_IDX_W-1:0] REG_ROWS_B = 2'd2;
    localparam logic [REG_IDX_W-1:0] REG_COLS_B = 2'd3;

    localparam logic [CFG_W-1:0] CFG_RESET = 4'd8;

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_RUN  = 4'b0010,
        ST_WAIT = 4'b0100,
        ST_OUT  = 4'b1000
    } t_state;

    typedef struct packed {
        logic clr;
        logic vld;
    } t_mac_ctl;

endpackage

### src/mm_if.sv
interface mm_in_if;
    logic                              valid;
    logic                              ready;
    logic [mm_pkg::CMD_W-1:0]          cmd;
    logic [mm_pkg::DIM_W-1:0]          row;
    logic [mm_pkg::DIM_W-1:0]          col;
    logic signed [mm_pkg::VAL_W-1:0]   value;

    modport source (output valid, cmd, row, col, value, input ready);
    modport sink   (input valid, cmd, row, col, value, output ready);
endinterface

interface mm_out_if;
    logic                              valid;
    logic                              ready;
    logic [mm_pkg::DIM_W-1:0]          out_row;
    logic [mm_pkg::DIM_W-1:0]          out_col;
    logic signed [mm_pkg::VAL_W-1:0]   out_value;
    logic                              last;
    logic                              size_error;

    modport source (output valid, out_row, out_col, out_value, last, size_error,
                    input ready);
    modport sink   (input valid, out_row, out_col, out_value, last, size_error,
                    output ready);
endinterface

interface mm_cfg_if;
    logic                              valid;
    logic                              ready;
    logic [mm_pkg::REG_IDX_W-1:0]      index;
    logic [mm_pkg::CFG_W-1:0]          data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

### src/mm_mac.sv
module mm_mac #(
    parameter int FRAC_BITS = 16
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  mm_pkg::t_mac_ctl                i_ctl,
    input  logic signed [mm_pkg::VAL_W-1:0] i_a,
    input  logic signed [mm_pkg::VAL_W-1:0] i_b,
    output logic                            o_busy,
    output logic signed [mm_pkg::VAL_W-1:0] o_result
);

    localparam int ACC_W  = mm_pkg::ACC_W;
    localparam int PROD_W = mm_pkg::PROD_W;
    localparam int VAL_W  = mm_pkg::VAL_W;

    logic signed [PROD_W-1:0] r_prod;
    logic                     r_v2;
    logic signed [ACC_W-1:0]  r_acc;
    logic signed [ACC_W-1:0]  shifted;
    logic [ACC_W-VAL_W:0]     top_bits;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v2 <= 1'b0;
        end else begin
            r_v2 <= i_ctl.vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_prod <= i_a * i_b;
        if (i_ctl.clr) begin
            r_acc <= '0;
        end else if (r_v2) begin
            r_acc <= r_acc + {{(ACC_W-PROD_W){r_prod[PROD_W-1]}}, r_prod};
        end
    end

    // arithmetic shift floors; saturate when the upper bits are not a sign run
    assign shifted  = r_acc >>> FRAC_BITS;
    assign top_bits = shifted[ACC_W-1:VAL_W-1];

    always_comb begin
        if ((&top_bits) || !(|top_bits)) begin
            o_result = shifted[VAL_W-1:0];
        end else if (shifted[ACC_W-1]) begin
            o_result = {1'b1, {(VAL_W-1){1'b0}}};
        end else begin
            o_result = {1'b0, {(VAL_W-1){1'b1}}};
        end
    end

    assign o_busy = r_v2;

endmodule

### src/matrix_multiply.sv
// Load beats do not leave the idle state, so the block stays ready for the next beat.
// A compute beat occupies the block for rows_a * cols_b elements; for each it
// issues cols_a store reads, drains the read, multiply and accumulate stages,
// then presents the result beat and holds it while the output stalls.
// A size mismatch yields its single result in the cycle after the compute beat.
// Synchronous active-low reset sets all sizes to 8; store contents are kept.
module matrix_multiply #(
    parameter int MAX_DIM   = 8,
    parameter int FRAC_BITS = 16
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    mm_cfg_if.sink     i_cfg,
    mm_in_if.sink      i_in,
    mm_out_if.source   o_out
);

    localparam int DEPTH  = MAX_DIM * MAX_DIM;
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CFG_W  = mm_pkg::CFG_W;
    localparam int DIM_W  = mm_pkg::DIM_W;
    localparam int VAL_W  = mm_pkg::VAL_W;
    localparam logic [CFG_W-1:0] DIM_LIMIT = CFG_W'(MAX_DIM);
    localparam logic [CFG_W-1:0] ONE       = CFG_W'(1);

    logic [CFG_W-1:0] r_rows_a, r_cols_a, r_rows_b, r_cols_b;
    logic [CFG_W-1:0] ra, ca, rb, cb;

    mm_pkg::t_state r_state, n_state;
    logic [DIM_W-1:0] r_i, n_i, r_j, n_j;
    logic [CFG_W-1:0] r_k, n_k;
    logic             r_v1;

    logic             r_out_vld, n_out_vld;
    logic [DIM_W-1:0] r_out_row, n_out_row, r_out_col, n_out_col;
    logic signed [VAL_W-1:0] r_out_value, n_out_value;
    logic             r_out_last, n_out_last, r_out_err, n_out_err;

    logic signed [VAL_W-1:0] r_left_mem  [DEPTH];
    logic signed [VAL_W-1:0] r_right_mem [DEPTH];
    logic signed [VAL_W-1:0] r_left_rd, r_right_rd;

    logic              in_acc, wr_a, wr_b, compute, issue, clr;
    logic [ADDR_W-1:0] wr_addr, rd_addr_a, rd_addr_b;
    logic              mac_busy;
    logic signed [VAL_W-1:0] mac_result;
    mm_pkg::t_mac_ctl  mac_ctl;

    // sizes above the store dimension act as the store dimension
    assign ra = (r_rows_a > DIM_LIMIT) ? DIM_LIMIT : r_rows_a;
    assign ca = (r_cols_a > DIM_LIMIT) ? DIM_LIMIT : r_cols_a;
    assign rb = (r_rows_b > DIM_LIMIT) ? DIM_LIMIT : r_rows_b;
    assign cb = (r_cols_b > DIM_LIMIT) ? DIM_LIMIT : r_cols_b;

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rows_a <= mm_pkg::CFG_RESET;
            r_cols_a <= mm_pkg::CFG_RESET;
            r_rows_b <= mm_pkg::CFG_RESET;
            r_cols_b <= mm_pkg::CFG_RESET;
        end else if (i_cfg.valid) begin
            unique case (i_cfg.index)
                mm_pkg::REG_ROWS_A: r_rows_a <= i_cfg.data;
                mm_pkg::REG_COLS_A: r_cols_a <= i_cfg.data;
                mm_pkg::REG_ROWS_B: r_rows_b <= i_cfg.data;
                mm_pkg::REG_COLS_B: r_cols_b <= i_cfg.data;
            endcase
        end
    end

    assign i_in.ready = (r_state == mm_pkg::ST_IDLE);
    assign in_acc     = i_in.valid && i_in.ready;
    assign compute    = in_acc && (i_in.cmd == mm_pkg::CMD_COMPUTE);
    assign wr_a = in_acc && (i_in.cmd == mm_pkg::CMD_LOAD_A)
                  && ({1'b0, i_in.row} < ra) && ({1'b0, i_in.col} < ca);
    assign wr_b = in_acc && (i_in.cmd == mm_pkg::CMD_LOAD_B)
                  && ({1'b0, i_in.row} < rb) && ({1'b0, i_in.col} < cb);

    assign wr_addr   = ADDR_W'(int'(i_in.row) * MAX_DIM + int'(i_in.col));
    assign rd_addr_a = ADDR_W'(int'(r_i) * MAX_DIM + int'(r_k[DIM_W-1:0]));
    assign rd_addr_b = ADDR_W'(int'(r_k[DIM_W-1:0]) * MAX_DIM + int'(r_j));

    always_ff @(posedge i_clk) begin
        if (wr_a) begin
            r_left_mem[wr_addr] <= i_in.value;
        end
        if (wr_b) begin
            r_right_mem[wr_addr] <= i_in.value;
        end
        r_left_rd  <= r_left_mem[rd_addr_a];
        r_right_rd <= r_right_mem[rd_addr_b];
    end

    always_comb begin
        n_state     = r_state;
        n_i         = r_i;
        n_j         = r_j;
        n_k         = r_k;
        n_out_vld   = r_out_vld;
        n_out_row   = r_out_row;
        n_out_col   = r_out_col;
        n_out_value = r_out_value;
        n_out_last  = r_out_last;
        n_out_err   = r_out_err;
        issue       = 1'b0;
        clr         = 1'b0;
        unique case (r_state)
            mm_pkg::ST_IDLE: begin
                if (compute) begin
                    n_i = '0;
                    n_j = '0;
                    n_k = '0;
                    if (ca != rb) begin
                        n_out_vld   = 1'b1;
                        n_out_row   = '0;
                        n_out_col   = '0;
                        n_out_value = '0;
                        n_out_last  = 1'b1;
                        n_out_err   = 1'b1;
                        n_state     = mm_pkg::ST_OUT;
                    end else if ((ra != '0) && (cb != '0)) begin
                        clr     = 1'b1;
                        n_state = mm_pkg::ST_RUN;
                    end
                end
            end
            mm_pkg::ST_RUN: begin
                if (r_k < ca) begin
                    issue = 1'b1;
                    n_k   = r_k + ONE;
                end
                if ((r_k + ONE) >= ca) begin
                    n_state = mm_pkg::ST_WAIT;
                end
            end
            mm_pkg::ST_WAIT: begin
                // wait for the read and product stages to empty
                if (!r_v1 && !mac_busy) begin
                    n_out_vld   = 1'b1;
                    n_out_row   = r_i;
                    n_out_col   = r_j;
                    n_out_value = mac_result;
                    n_out_last  = ({1'b0, r_i} == (ra - ONE))
                                  && ({1'b0, r_j} == (cb - ONE));
                    n_out_err   = 1'b0;
                    n_state     = mm_pkg::ST_OUT;
                end
            end
            mm_pkg::ST_OUT: begin
                if (o_out.ready) begin
                    n_out_vld = 1'b0;
                    if (r_out_last) begin
                        n_state = mm_pkg::ST_IDLE;
                    end else begin
                        n_k     = '0;
                        clr     = 1'b1;
                        n_state = mm_pkg::ST_RUN;
                        if (({1'b0, r_j} + ONE) == cb) begin
                            n_j = '0;
                            n_i = r_i + DIM_W'(1);
                        end else begin
                            n_j = r_j + DIM_W'(1);
                        end
                    end
                end
            end
            default: begin
                n_state = mm_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= mm_pkg::ST_IDLE;
            r_v1      <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_v1      <= issue;
            r_out_vld <= n_out_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_i         <= n_i;
        r_j         <= n_j;
        r_k         <= n_k;
        r_out_row   <= n_out_row;
        r_out_col   <= n_out_col;
        r_out_value <= n_out_value;
        r_out_last  <= n_out_last;
        r_out_err   <= n_out_err;
    end

    assign mac_ctl.clr = clr;
    assign mac_ctl.vld = r_v1;

    mm_mac #(
        .FRAC_BITS (FRAC_BITS)
    ) u_mac (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ctl    (mac_ctl),
        .i_a      (r_left_rd),
        .i_b      (r_right_rd),
        .o_busy   (mac_busy),
        .o_result (mac_result)
    );

    assign o_out.valid      = r_out_vld;
    assign o_out.out_row    = r_out_row;
    assign o_out.out_col    = r_out_col;
    assign o_out.out_value  = r_out_value;
    assign o_out.last       = r_out_last;
    assign o_out.size_error = r_out_err;

    a_idle_has_no_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in.ready |-> !o_out.valid)
        else $error("input ready while a result is pending");

    a_error_is_final: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.size_error) |-> (o_out.last && (o_out.out_value == '0)))
        else $error("size error beat not final or not zero");

    a_last_at_corner: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.last && !o_out.size_error)
        |-> (({1'b0, o_out.out_row} == (ra - ONE)) && ({1'b0, o_out.out_col} == (cb - ONE))))
        else $error("last flag away from final element");

    a_no_issue_when_draining: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == mm_pkg::ST_OUT) |-> (!r_v1 && !mac_busy))
        else $error("products in flight while a result is held");

endmodule
